### hdl/pfbt_pkg.sv
// Shared types and constants for the path failure breaker table.
`default_nettype none
package pfbt_pkg;

  localparam int COUNT_W = 16;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd3;
  localparam logic [CFG_W-1:0] WINDOW_RST    = 32'd60;
  localparam logic [CFG_W-1:0] CD_BASE_RST   = 32'd1;
  localparam logic [CFG_W-1:0] CD_MAX_RST    = 32'd300;

  typedef enum logic [1:0] {
    FUNC_QUERY   = 2'd0,
    FUNC_FAIL    = 2'd1,
    FUNC_SUCCESS = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_CD_BASE   = 2'd2,
    REG_CD_MAX    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [CFG_W-1:0] window;
    logic [CFG_W-1:0] cd_base;
    logic [CFG_W-1:0] cd_max;
  } cfg_t;

  typedef struct packed {
    logic reach;
    logic pause;
  } upd_flags_t;

endpackage
`default_nettype wire

### hdl/pfbt_regs.sv
// APB configuration registers of the path failure breaker table.
`default_nettype none
module pfbt_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [pfbt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pfbt_pkg::DATA_W-1:0] pwdata,
  output logic      [pfbt_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output pfbt_pkg::cfg_t                 cfg
);
  import pfbt_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  // Registers sit on word boundaries; the low address bits are ignored.
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RST;
      cfg.window    <= WINDOW_RST;
      cfg.cd_base   <= CD_BASE_RST;
      cfg.cd_max    <= CD_MAX_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg.threshold <= pwdata[THR_W-1:0];
        REG_WINDOW:    cfg.window    <= pwdata;
        REG_CD_BASE:   cfg.cd_base   <= pwdata;
        REG_CD_MAX:    cfg.cd_max    <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg.threshold);
      REG_WINDOW:    prdata = cfg.window;
      REG_CD_BASE:   prdata = cfg.cd_base;
      REG_CD_MAX:    prdata = cfg.cd_max;
    endcase
  end

endmodule
`default_nettype wire

### hdl/pfbt_update.sv
// Next-entry logic for one beat: failure run, backoff cooldown and pause.
`default_nettype none
module pfbt_update #(
  parameter int TIME_BITS = 48
) (
  input  pfbt_pkg::cfg_t                    cfg,
  input  wire logic [1:0]                   func,
  input  wire logic                         valid,
  input  wire logic [TIME_BITS-1:0]         now,
  input  wire logic [pfbt_pkg::COUNT_W-1:0] count,
  input  wire logic [TIME_BITS-1:0]         last,
  input  wire logic [TIME_BITS-1:0]         cooldown,
  input  wire logic [TIME_BITS-1:0]         resume,
  output logic      [pfbt_pkg::COUNT_W-1:0] count_next,
  output logic      [TIME_BITS-1:0]         last_next,
  output logic      [TIME_BITS-1:0]         cooldown_next,
  output logic      [TIME_BITS-1:0]         resume_next,
  output pfbt_pkg::upd_flags_t              flags
);
  import pfbt_pkg::*;

  // Compare width that holds both a time value and a 32-bit register.
  localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [COUNT_W-1:0]   cur_count;
  logic [TIME_BITS-1:0] cur_last;
  logic [TIME_BITS-1:0] cur_cd;
  logic [TIME_BITS-1:0] cur_res;
  logic [TIME_BITS-1:0] elapsed;
  logic                 late;
  logic [THR_W-1:0]     thr;
  logic                 hit;
  logic [TIME_BITS-1:0] cd_dbl;
  logic [TIME_BITS-1:0] cd_clip;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] res_hit;
  logic                 now_ge_res;

  // An entry that is not valid starts from all zeros.
  assign cur_count = valid ? count    : '0;
  assign cur_last  = valid ? last     : '0;
  assign cur_cd    = valid ? cooldown : '0;
  assign cur_res   = valid ? resume   : '0;

  // Time going backwards counts as no time elapsed.
  assign elapsed = now - cur_last;
  assign late    = (now >= cur_last) && (CW'(elapsed) > CW'(cfg.window));

  always_comb begin
    if (cur_count == '0 || late) begin
      count_next = COUNT_W'(1);
    end else if (cur_count != COUNT_MAX) begin
      count_next = cur_count + COUNT_W'(1);
    end else begin
      count_next = cur_count;
    end
  end

  assign last_next = now;

  assign cd_dbl  = {cur_cd[TIME_BITS-2:0], 1'b0};
  assign cd_clip = (CW'(cd_dbl) > CW'(cfg.cd_max)) ? TIME_BITS'(cfg.cd_max) : cd_dbl;
  assign cooldown_next = (cur_cd == '0) ? TIME_BITS'(cfg.cd_base) : cd_clip;

  // A threshold of zero behaves as one.
  assign thr = (cfg.threshold == '0) ? THR_W'(1) : cfg.threshold;
  assign hit = (COUNT_W'(count_next) >= COUNT_W'(thr));

  assign sum     = {1'b0, now} + {1'b0, cooldown_next};
  assign res_hit = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign resume_next = hit ? res_hit : cur_res;

  assign now_ge_res = (now >= cur_res);

  always_comb begin
    flags.pause = 1'b0;
    unique case (func)
      FUNC_FAIL: begin
        flags.pause = hit;
        // A fresh pause ends at now plus the cooldown, which lies at now
        // only for a zero cooldown or when the sum saturates at now.
        if (hit) begin
          flags.reach = (cooldown_next == '0) || (now == '1);
        end else begin
          flags.reach = now_ge_res;
        end
      end
      FUNC_SUCCESS: flags.reach = 1'b1;
      default:      flags.reach = !valid || now_ge_res;
    endcase
  end

endmodule
`default_nettype wire

### hdl/path_failure_breaker_table_top.sv
// Top level of the path failure breaker table: stream ports, table and output register.
`default_nettype none
// The block tracks failures per path in a table of NUM_PATHS entries and
// answers, for every input beat, whether the addressed path is reachable
// after the beat has been applied, together with a sticky flag that is set
// once any path has ever been paused. An input beat is a query, a failure
// report or a success report. One beat is accepted every clock cycle when
// the output side keeps up. The table memory is read into a register on
// the edge that accepts a beat; the update, the write-back and the load of
// the output register happen together on the edge at which the update
// stage moves on, which waits while the output register is full and not
// being taken. The result is held in the output register until the master
// side takes it. A beat accepted on the same edge as the write-back of a
// failure report to the same path is served from a one-entry bypass
// register, so back-to-back beats to one path are exact. A path index at
// or above NUM_PATHS has no entry and always reports reachable. The
// configuration registers are written over the APB port at byte addresses
// 0 (error threshold), 4 (error window), 8 (cooldown base) and 12
// (cooldown maximum); they are meant to be changed only while the block
// is idle. Stored counts and times need no clearing after reset: each
// entry carries a valid bit that reset clears.
module path_failure_breaker_table_top #(
  parameter int NUM_PATHS = 64,
  parameter int TIME_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0 up: func[1:0], path_index[7:2], now[55:8].
  input  wire logic [55:0]                   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // Fields from bit 0 up: path_reachable[0], any_exclusion[1], zero fill.
  output logic      [7:0]                    m_axis_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfbt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pfbt_pkg::DATA_W-1:0]   pwdata,
  output logic      [pfbt_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import pfbt_pkg::*;

  localparam int AW      = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int ENTRY_W = COUNT_W + 3 * TIME_BITS;

  cfg_t cfg;

  // Input fields.
  logic [1:0]           in_func;
  logic [5:0]           in_path;
  logic [47:0]          in_now;
  logic [AW-1:0]        in_addr;
  logic                 in_inside;
  logic                 s_accept;

  // Update stage.
  logic                 s1_valid;
  logic [1:0]           s1_func;
  logic                 s1_inside;
  logic [AW-1:0]        s1_addr;
  logic [TIME_BITS-1:0] s1_now;
  logic                 adv;

  // Table memory and bypass.
  logic [ENTRY_W-1:0]   mem [NUM_PATHS];
  logic [ENTRY_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   fwd_data;
  logic                 fwd_hit;
  logic [ENTRY_W-1:0]   cur_entry;
  logic [ENTRY_W-1:0]   new_entry;
  logic                 wr_en;
  logic [NUM_PATHS-1:0] entry_valid;
  logic                 cur_valid;

  logic [COUNT_W-1:0]   count_next;
  logic [TIME_BITS-1:0] last_next;
  logic [TIME_BITS-1:0] cooldown_next;
  logic [TIME_BITS-1:0] resume_next;
  upd_flags_t           flags;

  logic                 exclusion_seen;
  logic                 excl_next;
  logic                 reach;

  // Output register.
  logic                 o_valid;
  logic                 o_reach;
  logic                 o_excl;

  pfbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_func   = s_axis_tdata[1:0];
  assign in_path   = s_axis_tdata[7:2];
  assign in_now    = s_axis_tdata[55:8];
  assign in_addr   = AW'(in_path);
  assign in_inside = (32'(in_path) < NUM_PATHS);

  // The update stage moves on when the output register is free or emptying.
  assign adv           = s1_valid && (!o_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_func   <= in_func;
      s1_inside <= in_inside;
      s1_addr   <= in_addr;
      s1_now    <= TIME_BITS'(in_now);
    end
  end

  // Only failure reports change the stored fields of an entry.
  assign wr_en     = adv && s1_inside && (func_t'(s1_func) == FUNC_FAIL);
  assign new_entry = {count_next, last_next, cooldown_next, resume_next};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= new_entry;
    end
    if (s_accept) begin
      rd_data <= mem[in_addr];
    end
  end

  // A read issued on the same edge as a write to the same entry returns the
  // old word, so the written word is kept for the beat that follows.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (s_accept) begin
      fwd_hit <= wr_en && (s1_addr == in_addr);
    end
  end

  assign cur_entry = fwd_hit ? fwd_data : rd_data;
  assign cur_valid = s1_inside && entry_valid[s1_addr];

  pfbt_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .cfg           (cfg),
    .func          (s1_func),
    .valid         (cur_valid),
    .now           (s1_now),
    .count         (cur_entry[ENTRY_W-1 -: COUNT_W]),
    .last          (cur_entry[3*TIME_BITS-1 -: TIME_BITS]),
    .cooldown      (cur_entry[2*TIME_BITS-1 -: TIME_BITS]),
    .resume        (cur_entry[TIME_BITS-1:0]),
    .count_next    (count_next),
    .last_next     (last_next),
    .cooldown_next (cooldown_next),
    .resume_next   (resume_next),
    .flags         (flags)
  );

  // Valid bits: a failure opens an entry and a success removes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (adv && s1_inside) begin
      unique case (func_t'(s1_func))
        FUNC_FAIL:    entry_valid[s1_addr] <= 1'b1;
        FUNC_SUCCESS: entry_valid[s1_addr] <= 1'b0;
        default:      entry_valid[s1_addr] <= entry_valid[s1_addr];
      endcase
    end
  end

  assign excl_next = exclusion_seen || (s1_inside && flags.pause);
  assign reach     = !s1_inside || flags.reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      exclusion_seen <= 1'b0;
    end else if (adv) begin
      exclusion_seen <= excl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_reach <= reach;
      o_excl  <= excl_next;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {6'b0, o_excl, o_reach};

endmodule
`default_nettype wire
